### sv/ppd_pkg.sv
package ppd_pkg;

    localparam int PPD_QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_X      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Y      = 2'd2;

    localparam logic [1:0] CMD_PS2       = 2'd0;
    localparam logic [1:0] CMD_USB       = 2'd1;
    localparam logic [1:0] CMD_WHEEL_CLR = 2'd2;

    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    localparam logic [11:0] MAX_X_RST    = 12'd1023;
    localparam logic [11:0] MAX_Y_RST    = 12'd767;
    localparam logic [11:0] CURSOR_X_RST = 12'd512;
    localparam logic [11:0] CURSOR_Y_RST = 12'd384;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_MOVE,
        OP_DROP,
        OP_WHEEL_CLR
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [2:0]         buttons;
        logic               has_wheel;
        logic signed [7:0]  wheel;
    } op_t;

    typedef struct packed {
        logic [11:0] max_x;
        logic [11:0] max_y;
    } limits_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         rx_byte;
        logic signed [15:0] usb_dx;
        logic signed [15:0] usb_dy;
        logic [7:0]         usb_buttons;
    } in_item_t;

    typedef struct packed {
        logic [11:0]        pos_x;
        logic [11:0]        pos_y;
        logic [2:0]         button_state;
        logic signed [15:0] wheel_total;
        logic               packet_applied;
        logic               packet_discarded;
    } out_item_t;

endpackage

### sv/ppd_front.sv
module ppd_front import ppd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     wheel_mode,
    input  logic     q_full,
    output logic     q_push,
    output op_t      q_op
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_X,
        PH_Y,
        PH_WHEEL
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] y_sel;
    logic       accept;
    op_kind_t   ps2_kind;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign q_push   = accept;

    assign y_sel    = (phase_reg == PH_Y) ? in_data.rx_byte : y_reg;
    assign ps2_kind = (header_reg[X_OVF_BIT] | header_reg[Y_OVF_BIT]) ? OP_DROP : OP_MOVE;

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_next      = x_reg;
        y_next      = y_reg;

        q_op.kind      = OP_REPORT;
        q_op.dx        = {{7{header_reg[X_SIGN_BIT]}}, header_reg[X_SIGN_BIT], x_reg};
        q_op.dy        = {{7{header_reg[Y_SIGN_BIT]}}, header_reg[Y_SIGN_BIT], y_sel};
        q_op.buttons   = header_reg[2:0];
        q_op.has_wheel = 1'b0;
        q_op.wheel     = in_data.rx_byte;

        case (in_data.cmd)
            CMD_PS2:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (in_data.rx_byte[SYNC_BIT])
                        begin
                            header_next = in_data.rx_byte;
                            phase_next  = PH_X;
                        end
                    end
                    PH_X:
                    begin
                        x_next     = in_data.rx_byte;
                        phase_next = PH_Y;
                    end
                    PH_Y:
                    begin
                        y_next = in_data.rx_byte;
                        if (wheel_mode)
                        begin
                            phase_next = PH_WHEEL;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            q_op.kind  = ps2_kind;
                        end
                    end
                    PH_WHEEL:
                    begin
                        phase_next     = PH_HEADER;
                        q_op.kind      = ps2_kind;
                        q_op.has_wheel = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
            CMD_USB:
            begin
                q_op.kind    = OP_MOVE;
                q_op.dx      = in_data.usb_dx;
                q_op.dy      = in_data.usb_dy;
                q_op.buttons = in_data.usb_buttons[2:0];
            end
            CMD_WHEEL_CLR:
            begin
                q_op.kind = OP_WHEEL_CLR;
            end
            default:
            begin
                q_op.kind = OP_REPORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

endmodule

### sv/ppd_fifo.sv
module ppd_fifo import ppd_pkg::*;
#(
    parameter int DEPTH = PPD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output op_t  pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

### sv/ppd_back.sv
module ppd_back import ppd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  op_t       q_op,
    output logic      q_pop,
    input  limits_t   limits,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [11:0]        cursor_x_reg, cursor_x_next;
    logic [11:0]        cursor_y_reg, cursor_y_next;
    logic [2:0]         buttons_reg, buttons_next;
    logic signed [15:0] wheel_reg, wheel_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg, out_next;

    logic               take;
    logic signed [17:0] sum_x, sum_y;
    logic signed [16:0] wheel_sum;
    logic signed [15:0] wheel_sat;

    function automatic logic [11:0] clamp_to(input logic signed [17:0] v,
                                             input logic [11:0] hi);
        logic [11:0] r;
        if (v < 18'sd0)
        begin
            r = '0;
        end
        else if (v > $signed({6'b0, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[11:0];
        end
        return r;
    endfunction

    assign take      = q_valid & (~out_valid_reg | ~out_stall);
    assign q_pop     = take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sum_x = $signed({6'b0, cursor_x_reg}) + {{2{q_op.dx[15]}}, q_op.dx};
    assign sum_y = $signed({6'b0, cursor_y_reg}) - {{2{q_op.dy[15]}}, q_op.dy};

    assign wheel_sum = {wheel_reg[15], wheel_reg} + {{9{q_op.wheel[7]}}, q_op.wheel};
    assign wheel_sat = (wheel_sum[16] != wheel_sum[15])
                     ? (wheel_sum[16] ? 16'sh8000 : 16'sh7fff)
                     : wheel_sum[15:0];

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        buttons_next  = buttons_reg;
        wheel_next    = wheel_reg;
        out_next.packet_applied   = 1'b0;
        out_next.packet_discarded = 1'b0;
        out_next.wheel_total      = wheel_reg;

        case (q_op.kind)
            OP_MOVE:
            begin
                cursor_x_next = clamp_to(sum_x, limits.max_x);
                cursor_y_next = clamp_to(sum_y, limits.max_y);
                buttons_next  = q_op.buttons;
                if (q_op.has_wheel)
                begin
                    wheel_next = wheel_sat;
                end
                out_next.packet_applied = 1'b1;
                out_next.wheel_total    = wheel_next;
            end
            OP_DROP:
            begin
                out_next.packet_discarded = 1'b1;
            end
            OP_WHEEL_CLR:
            begin
                wheel_next = '0;
            end
            default:
            begin
                wheel_next = wheel_reg;
            end
        endcase

        out_next.pos_x        = cursor_x_next;
        out_next.pos_y        = cursor_y_next;
        out_next.button_state = buttons_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= CURSOR_X_RST;
            cursor_y_reg  <= CURSOR_Y_RST;
            buttons_reg   <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                buttons_reg   <= buttons_next;
                wheel_reg     <= wheel_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_next;
        end
    end

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.packet_applied && out_data_reg.packet_discarded))
        else $error("applied and discarded both set");

    a_wheel_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_op.kind == OP_WHEEL_CLR) |=> (wheel_reg == 16'sd0))
        else $error("wheel not cleared");

    a_move_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_op.kind == OP_MOVE) |=>
            (out_data_reg.pos_x <= $past(limits.max_x)
             && out_data_reg.pos_y <= $past(limits.max_y)))
        else $error("cursor beyond limits after move");

endmodule

### sv/pointer_packet_decoder_unit.sv
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   in_data   (in_item_t)
// out      out  out_valid / out_stall out_data  (out_item_t)
// cfg      in   cfg_we                cfg_index, cfg_data
//
// One transaction per cycle while the queue is not full; a result is registered in the
// queue entry, then in the back output register.
// The back update of cursor and wheel is a combinational add and clamp.
// Reset clears framing, buttons and wheel; cursor to (512, 384), limits to (1023, 767).
// A stalled output fills the queue; in_stall rises only when it is full.
module pointer_packet_decoder_unit import ppd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PPD_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    wheel_mode_reg;
    limits_t limits_reg;

    logic q_full;
    logic q_push;
    op_t  q_push_op;
    logic q_pop;
    logic q_valid;
    op_t  q_pop_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg   <= 1'b0;
            limits_reg.max_x <= MAX_X_RST;
            limits_reg.max_y <= MAX_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WHEEL_MODE: wheel_mode_reg   <= cfg_data[0];
                CFG_MAX_X:      limits_reg.max_x <= cfg_data[11:0];
                CFG_MAX_Y:      limits_reg.max_y <= cfg_data[11:0];
                default:        wheel_mode_reg   <= wheel_mode_reg;
            endcase
        end
    end

    ppd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .wheel_mode (wheel_mode_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_push_op)
    );

    ppd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_push_op),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_op    (q_pop_op)
    );

    ppd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_pop_op),
        .q_pop     (q_pop),
        .limits    (limits_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/ppd_check.sv
module ppd_check import ppd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    outstanding,
    output int                    n_checked,
    output int                    n_applied,
    output int                    n_discarded
);

    typedef enum logic [1:0] {
        WAIT_HDR,
        GOT_HDR,
        GOT_X,
        GOT_Y
    } frame_t;

    logic        wheel_on;
    logic [11:0] lim_x;
    logic [11:0] lim_y;

    frame_t      frame;
    logic [7:0]  hdr;
    logic [7:0]  x_raw;
    logic [7:0]  y_raw;
    int          cur_x;
    int          cur_y;
    logic [2:0]  held;
    int          wheel_acc;

    out_item_t   due_reports[$];

    task automatic report(input string msg);
        errors++;
        if (errors <= 100)
            $display("ppd_check: %s", msg);
    endtask

    function automatic int clamp_pos(input int v, input logic [11:0] hi);
        if (v < 0)
            return 0;
        if (v > int'(hi))
            return int'(hi);
        return v;
    endfunction

    function automatic void shift_cursor(input int dx, input int dy);
        cur_x = clamp_pos(cur_x + dx, lim_x);
        cur_y = clamp_pos(cur_y - dy, lim_y);
    endfunction

    // returns 1 when the packet moved the cursor, 0 when dropped for overflow
    function automatic bit close_packet(input bit with_wheel, input logic [7:0] wb);
        int dx;
        int dy;
        if (hdr[X_OVF_BIT] || hdr[Y_OVF_BIT])
            return 1'b0;
        held = hdr[2:0];
        dx = hdr[X_SIGN_BIT] ? int'(x_raw) - 256 : int'(x_raw);
        dy = hdr[Y_SIGN_BIT] ? int'(y_raw) - 256 : int'(y_raw);
        shift_cursor(dx, dy);
        if (with_wheel)
        begin
            wheel_acc = wheel_acc + int'($signed(wb));
            if (wheel_acc > 32767)
                wheel_acc = 32767;
            if (wheel_acc < -32768)
                wheel_acc = -32768;
        end
        return 1'b1;
    endfunction

    function automatic out_item_t cursor_report_of(input in_item_t t);
        out_item_t r;
        int        wheel_shown;
        bit        ok;
        r = '0;
        wheel_shown = wheel_acc;
        case (t.cmd)
            CMD_PS2:
            begin
                case (frame)
                    WAIT_HDR:
                    begin
                        if (t.rx_byte[SYNC_BIT])
                        begin
                            hdr = t.rx_byte;
                            frame = GOT_HDR;
                        end
                    end
                    GOT_HDR:
                    begin
                        x_raw = t.rx_byte;
                        frame = GOT_X;
                    end
                    GOT_X:
                    begin
                        y_raw = t.rx_byte;
                        if (wheel_on)
                            frame = GOT_Y;
                        else
                        begin
                            frame = WAIT_HDR;
                            ok = close_packet(1'b0, 8'h00);
                            r.packet_applied = ok;
                            r.packet_discarded = !ok;
                        end
                    end
                    default:
                    begin
                        frame = WAIT_HDR;
                        ok = close_packet(1'b1, t.rx_byte);
                        r.packet_applied = ok;
                        r.packet_discarded = !ok;
                    end
                endcase
                wheel_shown = wheel_acc;
            end
            CMD_USB:
            begin
                shift_cursor(int'($signed(t.usb_dx)), int'($signed(t.usb_dy)));
                held = t.usb_buttons[2:0];
                r.packet_applied = 1'b1;
                wheel_shown = wheel_acc;
            end
            CMD_WHEEL_CLR:
            begin
                wheel_shown = wheel_acc;
                wheel_acc = 0;
            end
            default:
                wheel_shown = wheel_acc;
        endcase
        r.pos_x = cur_x[11:0];
        r.pos_y = cur_y[11:0];
        r.button_state = held;
        r.wheel_total = wheel_shown[15:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             n_checked, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            wheel_on = 1'b0;
            lim_x = MAX_X_RST;
            lim_y = MAX_Y_RST;
            frame = WAIT_HDR;
            hdr = '0;
            x_raw = '0;
            y_raw = '0;
            cur_x = int'(CURSOR_X_RST);
            cur_y = int'(CURSOR_Y_RST);
            held = '0;
            wheel_acc = 0;
            due_reports.delete();
            errors = 0;
            outstanding = 0;
            n_checked = 0;
            n_applied = 0;
            n_discarded = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                    report("result transaction with nothing expected");
                else
                begin
                    want = due_reports.pop_front();
                    check_field("pos_x", 16'(out_data.pos_x), 16'(want.pos_x));
                    check_field("pos_y", 16'(out_data.pos_y), 16'(want.pos_y));
                    check_field("button_state", 16'(out_data.button_state),
                                16'(want.button_state));
                    check_field("wheel_total", out_data.wheel_total, want.wheel_total);
                    check_field("packet_applied", 16'(out_data.packet_applied),
                                16'(want.packet_applied));
                    check_field("packet_discarded", 16'(out_data.packet_discarded),
                                16'(want.packet_discarded));
                    n_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WHEEL_MODE: wheel_on = cfg_data[0];
                    CFG_MAX_X:      lim_x = cfg_data;
                    CFG_MAX_Y:      lim_y = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want = cursor_report_of(in_data);
                if (want.packet_applied)
                    n_applied++;
                if (want.packet_discarded)
                    n_discarded++;
                due_reports.push_back(want);
            end
            outstanding = due_reports.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import ppd_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int outstanding;
    int n_checked;
    int n_applied;
    int n_discarded;

    int send_idle;
    int recv_idle;
    int n_sent;
    int n_writes;
    int cycles;
    bit mode_now;

    pointer_packet_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ppd_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .n_checked   (n_checked),
        .n_applied   (n_applied),
        .n_discarded (n_discarded)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: cycle limit reached");
            $display("tb: failure");
            $finish;
        end
    end

    function automatic in_item_t rand_item(input logic [1:0] c);
        in_item_t it;
        it.cmd = c;
        it.rx_byte = 8'($urandom);
        it.usb_dx = 16'($urandom);
        it.usb_dy = 16'($urandom);
        it.usb_buttons = 8'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] usb_delta();
        if ($urandom_range(4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(600) - 300);
    endfunction

    task automatic push_item(input in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
    endtask

    task automatic ps2_byte(input logic [7:0] b);
        in_item_t it;
        it = rand_item(CMD_PS2);
        it.rx_byte = b;
        push_item(it);
    endtask

    task automatic ps2_packet(input logic [7:0] h, input logic [7:0] x,
                              input logic [7:0] y, input logic [7:0] w);
        ps2_byte(h);
        ps2_byte(x);
        ps2_byte(y);
        if (mode_now)
            ps2_byte(w);
    endtask

    task automatic usb_report(input logic [15:0] dx, input logic [15:0] dy,
                              input logic [7:0] btn);
        in_item_t it;
        it = rand_item(CMD_USB);
        it.usb_dx = dx;
        it.usb_dy = dy;
        it.usb_buttons = btn;
        push_item(it);
    endtask

    // hold off the sender until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input bit mode, input logic [11:0] mx,
                                 input logic [11:0] my);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WHEEL_MODE;
        cfg_data <= {11'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_MAX_X;
        cfg_data <= mx;
        @(posedge clk);
        cfg_index <= CFG_MAX_Y;
        cfg_data <= my;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_writes += 3;
        mode_now = mode;
    endtask

    function automatic logic [7:0] good_header();
        logic [7:0] h;
        h = 8'($urandom);
        h[SYNC_BIT] = 1'b1;
        h[X_OVF_BIT] = 1'b0;
        h[Y_OVF_BIT] = 1'b0;
        return h;
    endfunction

    task automatic random_step();
        int         r;
        logic [7:0] h;
        r = $urandom_range(99);
        if (r < 60)
        begin
            h = good_header();
            if ($urandom_range(9) == 0)
            begin
                h[X_OVF_BIT] = 1'($urandom);
                h[Y_OVF_BIT] = 1'($urandom);
            end
            ps2_packet(h, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (r < 75)
            usb_report(usb_delta(), usb_delta(), 8'($urandom));
        else if (r < 83)
            push_item(rand_item(CMD_WHEEL_CLR));
        else if (r < 88)
            push_item(rand_item(CMD_SPARE));
        else
            ps2_byte(8'($urandom));
    endtask

    task automatic run_segment(input int count);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at)
            random_step();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        send_idle = 0;
        recv_idle = 0;
        n_sent = 0;
        n_writes = 0;
        mode_now = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(rand_item(CMD_SPARE));
        usb_report(16'h0000, 16'h0000, 8'hFF);
        usb_report(16'h7FFF, 16'h8000, 8'h00);
        usb_report(16'h8000, 16'h7FFF, 8'h05);
        ps2_byte(8'h00);
        ps2_byte(8'hF7);
        ps2_packet(8'h3F, 8'h00, 8'h00, 8'h00);
        ps2_packet(8'h08, 8'hFF, 8'hFF, 8'h00);
        ps2_packet(8'hC8, 8'h12, 8'h34, 8'h00);
        push_item(rand_item(CMD_WHEEL_CLR));
        settle();
        apply_setting(1'b1, 12'd4095, 12'd4095);
        ps2_packet(8'h08, 8'h01, 8'h01, 8'h80);
        ps2_byte(8'h09);
        ps2_byte(8'h02);
        ps2_byte(8'h03);
        // framer already holds three bytes of a wheel packet
        settle();
        apply_setting(1'b0, 12'd0, 12'd0);
        ps2_byte(8'h7F);
        push_item(rand_item(CMD_WHEEL_CLR));

        send_idle = 30;
        recv_idle = 58;
        settle();
        apply_setting(1'b1, 12'd4095, 12'd4095);
        run_segment(125);
        settle();
        apply_setting(1'b0, 12'd0, 12'd0);
        run_segment(125);
        settle();
        apply_setting(1'b1, 12'd100, 12'd50);
        run_segment(125);

        send_idle = 58;
        recv_idle = 30;
        settle();
        apply_setting(1'b0, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        run_segment(125);
        settle();
        apply_setting(1'b1, MAX_X_RST, MAX_Y_RST);
        run_segment(125);
        settle();
        apply_setting(1'b0, 12'd4095, 12'd0);
        run_segment(125);

        send_idle = 0;
        recv_idle = 0;
        settle();
        apply_setting(1'b1, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        run_segment(125);
        settle();
        apply_setting(1'b0, 12'd0, 12'd4095);
        run_segment(125);
        settle();
        apply_setting(1'b1, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        run_segment(125);

        settle();
        repeat (20)
            @(posedge clk);

        $display("tb_top: %0d input transactions, %0d results checked",
                 n_sent, n_checked);
        $display("tb_top: %0d packets applied, %0d discarded, %0d register writes, %s",
                 n_applied, n_discarded, n_writes, "three stall mixes");
        if (outstanding != 0)
            $display("tb_top: %0d expected results never arrived", outstanding);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
